/* rtl/core/khdt_pkg.sv */
// ----------------------------------------------------------------------------
// khdt_pkg
// Shared types and constants of the held-key delay tracker.
// ----------------------------------------------------------------------------
package khdt_pkg;

    // Table geometry
    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int HCNT_W      = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int KEY_W  = 9;
    localparam int TIME_W = 16;
    localparam int CD_W   = TIME_W + 1;
    localparam int OP_W   = 2;
    localparam int EVT_W  = 2;

    // Reset value of the hold delay, in milliseconds
    localparam logic [TIME_W-1:0] HOLD_DELAY_RST = TIME_W'(120);

    // Depth of the command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [EVT_W-1:0] {
        EVT_TRIGGERED = 2'd0,
        EVT_RELEASED  = 2'd1,
        EVT_HELD      = 2'd2
    } t_evt;

    // One classified command: arg is the hold delay on a press, the
    // elapsed time on a tick, unused on a release
    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] arg;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_PRESS,
        BS_RELEASE,
        BS_TICK
    } t_bstate;

endpackage

/* rtl/core/khdt_front.sv */
// ----------------------------------------------------------------------------
// khdt_front
// Accepts input items, drops unknown operations, holds the delay register
// and forms commands for the queue.
// ----------------------------------------------------------------------------
module khdt_front import khdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [KEY_W-1:0]  i_key_code,
    input  logic [TIME_W-1:0] i_elapsed_ms,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TIME_W-1:0] i_cfg_hold_delay_ms,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    logic [TIME_W-1:0] r_hold_delay;
    logic              accept;
    logic              known;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full;
    assign accept      = i_valid && !i_q_full;

    // Hold the delay register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_delay <= HOLD_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hold_delay <= i_cfg_hold_delay_ms;
        end
    end

    // Classify the item and attach its time argument
    always_comb begin
        known          = 1'b1;
        o_q_cmd.op     = OP_PRESS;
        o_q_cmd.key    = i_key_code;
        o_q_cmd.arg    = r_hold_delay;
        unique case (i_operation)
            OP_PRESS: begin
                o_q_cmd.op  = OP_PRESS;
                o_q_cmd.arg = r_hold_delay;
            end
            OP_RELEASE: begin
                o_q_cmd.op  = OP_RELEASE;
            end
            OP_TICK: begin
                o_q_cmd.op  = OP_TICK;
                o_q_cmd.arg = i_elapsed_ms;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_q_push = accept && known;

endmodule

/* rtl/core/khdt_queue.sv */
// ----------------------------------------------------------------------------
// khdt_queue
// Short command queue that decouples the front from the table sequencer.
// ----------------------------------------------------------------------------
module khdt_queue import khdt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_fill == (QAW+1)'(QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/khdt_back.sv */
// ----------------------------------------------------------------------------
// khdt_back
// Slot table and sequencer: appends on press, compacts on release, walks
// the countdowns on tick, and drives the result register.
// ----------------------------------------------------------------------------
module khdt_back import khdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [EVT_W-1:0]  o_event_kind,
    output logic [KEY_W-1:0]  o_event_key,
    output logic              o_table_overflow,
    output logic              o_last_of_run
);

    // Slot table, no reset: only entries below the count are read
    logic [KEY_W-1:0]       r_slot_key [SLOTS];
    logic signed [CD_W-1:0] r_slot_cd  [SLOTS];

    t_bstate           r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic              r_pend, n_pend;
    logic [KEY_W-1:0]  r_pend_key, n_pend_key;
    logic [HCNT_W-1:0] r_held_n, n_held_n;

    logic              r_out_valid, n_out_valid;
    logic [EVT_W-1:0]  r_out_kind, n_out_kind;
    logic [KEY_W-1:0]  r_out_key, n_out_key;
    logic              r_out_ovf, n_out_ovf;
    logic              r_out_last, n_out_last;

    logic                   out_ok;
    logic                   in_range;
    logic [KEY_W-1:0]       rd_key;
    logic signed [CD_W-1:0] rd_cd;
    logic                   wr_en;
    logic [SLOT_IW-1:0]     wr_addr;
    logic [KEY_W-1:0]       wr_key;
    logic signed [CD_W-1:0] wr_cd;

    assign out_ok   = !r_out_valid || !i_stall;
    assign in_range = (r_idx < r_count);
    assign rd_key   = r_slot_key[r_idx[SLOT_IW-1:0]];
    assign rd_cd    = r_slot_cd[r_idx[SLOT_IW-1:0]];

    // Next state, table writes and result loads
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_pend      = r_pend;
        n_pend_key  = r_pend_key;
        n_held_n    = r_held_n;
        n_out_valid = r_out_valid && i_stall;
        n_out_kind  = r_out_kind;
        n_out_key   = r_out_key;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_idx[SLOT_IW-1:0];
        wr_key      = rd_key;
        wr_cd       = rd_cd;

        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop    = 1'b1;
                    n_cmd      = i_q_cmd;
                    n_idx      = '0;
                    n_wr       = '0;
                    n_pend     = 1'b0;
                    n_held_n   = '0;
                    unique case (i_q_cmd.op)
                        OP_PRESS:   n_state = BS_PRESS;
                        OP_RELEASE: n_state = BS_RELEASE;
                        OP_TICK:    n_state = BS_TICK;
                        default:    n_state = BS_IDLE;
                    endcase
                end
            end

            BS_PRESS: begin
                // Append the slot if there is room, report the press
                if (out_ok) begin
                    if (r_count < CNT_W'(SLOTS)) begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[SLOT_IW-1:0];
                        wr_key  = r_cmd.key;
                        wr_cd   = $signed({1'b0, r_cmd.arg});
                        n_count = r_count + 1'b1;
                        n_out_ovf = 1'b0;
                    end else begin
                        n_out_ovf = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_out_kind  = EVT_TRIGGERED;
                    n_out_key   = r_cmd.key;
                    n_out_last  = 1'b1;
                    n_state     = BS_IDLE;
                end
            end

            BS_RELEASE: begin
                if (in_range) begin
                    // Copy down every slot that does not match the key
                    if (rd_key != r_cmd.key) begin
                        wr_en   = 1'b1;
                        wr_addr = r_wr[SLOT_IW-1:0];
                        n_wr    = r_wr + 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                end else if (out_ok) begin
                    n_count     = r_wr;
                    n_out_valid = 1'b1;
                    n_out_kind  = EVT_RELEASED;
                    n_out_key   = r_cmd.key;
                    n_out_ovf   = 1'b0;
                    n_out_last  = 1'b1;
                    n_state     = BS_IDLE;
                end
            end

            BS_TICK: begin
                if (in_range) begin
                    if (!rd_cd[CD_W-1]) begin
                        // Count the slot down
                        wr_en = 1'b1;
                        wr_cd = rd_cd - $signed({1'b0, r_cmd.arg});
                        n_idx = r_idx + 1'b1;
                    end else if (r_held_n < HCNT_W'(MAX_RESULTS)) begin
                        // Hold one held event back to learn if it is the last
                        if (!r_pend) begin
                            n_pend     = 1'b1;
                            n_pend_key = rd_key;
                            n_held_n   = r_held_n + 1'b1;
                            n_idx      = r_idx + 1'b1;
                        end else if (out_ok) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = EVT_HELD;
                            n_out_key   = r_pend_key;
                            n_out_ovf   = 1'b0;
                            n_out_last  = 1'b0;
                            n_pend_key  = rd_key;
                            n_held_n    = r_held_n + 1'b1;
                            n_idx       = r_idx + 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (!r_pend) begin
                    n_state = BS_IDLE;
                end else if (out_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = EVT_HELD;
                    n_out_key   = r_pend_key;
                    n_out_ovf   = 1'b0;
                    n_out_last  = 1'b1;
                    n_pend      = 1'b0;
                    n_state     = BS_IDLE;
                end
            end

            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // Write the slot table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_key[wr_addr] <= wr_key;
            r_slot_cd[wr_addr]  <= wr_cd;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_wr        <= '0;
            r_pend      <= 1'b0;
            r_held_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_wr        <= n_wr;
            r_pend      <= n_pend;
            r_held_n    <= n_held_n;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pend_key <= n_pend_key;
        r_out_kind <= n_out_kind;
        r_out_key  <= n_out_key;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign o_valid          = r_out_valid;
    assign o_event_kind     = r_out_kind;
    assign o_event_key      = r_out_key;
    assign o_table_overflow = r_out_ovf;
    assign o_last_of_run    = r_out_last;

endmodule

/* rtl/core/key_hold_delay_tracker_top.sv */
// ----------------------------------------------------------------------------
// key_hold_delay_tracker_top
// Held-key delay tracker: an ordered slot table of held keys with
// countdowns, reporting triggered, released and held events.
//
//   Channel   Direction  Handshake                Payload
//   input     in         i_valid / o_stall        operation, key_code, elapsed_ms
//   result    out        o_valid / i_stall        event_kind, event_key,
//                                                 table_overflow, last_of_run
//   config    in         i_cfg_valid / o_cfg_ready hold_delay_ms
//
// A release or a tick walks the table: the sequencer reads one table slot
// per cycle through a single read port, unless a tick waits to report a
// held event. Two commands queue ahead of the sequencer, so input transfers
// continue while a walk is under way. Stalls on the result side hold the
// walk only when an event is ready to leave. Reset is synchronous, active
// low, and empties the table and restores a hold delay of 120 ms.
// ----------------------------------------------------------------------------
module key_hold_delay_tracker_top import khdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [KEY_W-1:0]  i_key_code,
    input  logic [TIME_W-1:0] i_elapsed_ms,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [EVT_W-1:0]  o_event_kind,
    output logic [KEY_W-1:0]  o_event_key,
    output logic              o_table_overflow,
    output logic              o_last_of_run,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TIME_W-1:0] i_cfg_hold_delay_ms
);

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_pop;
    logic q_valid;
    t_cmd q_out_cmd;

    // Accept and classify
    khdt_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_operation         (i_operation),
        .i_key_code          (i_key_code),
        .i_elapsed_ms        (i_elapsed_ms),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_hold_delay_ms (i_cfg_hold_delay_ms),
        .i_q_full            (q_full),
        .o_q_push            (q_push),
        .o_q_cmd             (q_in_cmd)
    );

    // Queue commands between the two sides
    khdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // Carry out commands on the slot table
    khdt_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_out_cmd),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_event_key      (o_event_key),
        .o_table_overflow (o_table_overflow),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the held-key delay tracker. Press, release and
// tick commands are driven from a queue of pending commands, and a
// behavioural copy of the slot table predicts the events each accepted
// command must cause. Every event that leaves the block is compared, field
// by field, with the oldest prediction. The hold delay is rewritten between
// phases once the block has drained, and both sides insert random gaps,
// apart from one phase that runs back to back.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import khdt_pkg::*;

    localparam int             CLK_HALF     = 5;
    localparam int             LIMIT        = 200000;
    localparam int             DRAIN_CYCLES = 64;
    localparam int             GAP_PCT      = 24;
    localparam int             PHASE_CMDS   = 48;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] elapsed;
    } t_key_cmd;

    typedef struct packed {
        t_evt              kind;
        logic [KEY_W-1:0]  key;
        logic              overflow;
        logic              last;
    } t_key_event;

    logic              i_clk               = 1'b0;
    logic              i_rst_n             = 1'b0;
    logic              i_valid             = 1'b0;
    logic [OP_W-1:0]   i_operation         = '0;
    logic [KEY_W-1:0]  i_key_code          = '0;
    logic [TIME_W-1:0] i_elapsed_ms        = '0;
    logic              i_stall             = 1'b0;
    logic              i_cfg_valid         = 1'b0;
    logic [TIME_W-1:0] i_cfg_hold_delay_ms = '0;
    logic              o_stall;
    logic              o_valid;
    logic [EVT_W-1:0]  o_event_kind;
    logic [KEY_W-1:0]  o_event_key;
    logic              o_table_overflow;
    logic              o_last_of_run;
    logic              o_cfg_ready;

    // Commands waiting for the driver, events waiting for the block
    t_key_cmd          pending_cmds[$];
    t_key_event        expected_events[$];

    // Predicted slot table and hold delay
    logic [KEY_W-1:0]        held_key[SLOTS];
    logic signed [CD_W-1:0]  held_cd[SLOTS];
    int                      held_count = 0;
    logic [TIME_W-1:0]       hold_delay = HOLD_DELAY_RST;

    bit  no_gaps  = 1'b0;
    int  n_fail   = 0;
    int  cycles   = 0;

    key_hold_delay_tracker_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_operation         (i_operation),
        .i_key_code          (i_key_code),
        .i_elapsed_ms        (i_elapsed_ms),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_event_kind        (o_event_kind),
        .o_event_key         (o_event_key),
        .o_table_overflow    (o_table_overflow),
        .o_last_of_run       (o_last_of_run),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_hold_delay_ms (i_cfg_hold_delay_ms)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Apply one command to the predicted table and queue the events it causes
    function automatic void track_key_cmd(t_key_cmd c);
        t_key_event ev;
        int         n_held;
        int         w;
        n_held = 0;
        w      = 0;
        case (c.op)
            OP_PRESS: begin
                ev = '{EVT_TRIGGERED, c.key, held_count >= SLOTS, 1'b1};
                if (!ev.overflow) begin
                    held_key[held_count] = c.key;
                    held_cd[held_count]  = $signed({1'b0, hold_delay});
                    held_count++;
                end
                expected_events.insert(expected_events.size(), ev);
            end
            OP_RELEASE: begin
                // drop every slot of this key, keep the order of the rest
                for (int i = 0; i < held_count; i++) begin
                    if (held_key[i] != c.key) begin
                        held_key[w] = held_key[i];
                        held_cd[w]  = held_cd[i];
                        w++;
                    end
                end
                held_count = w;
                ev = '{EVT_RELEASED, c.key, 1'b0, 1'b1};
                expected_events.insert(expected_events.size(), ev);
            end
            OP_TICK: begin
                // count down live slots, report the expired ones in order
                for (int i = 0; i < held_count; i++) begin
                    if (held_cd[i] >= 0) begin
                        held_cd[i] = held_cd[i] - $signed({1'b0, c.elapsed});
                    end else if (n_held < MAX_RESULTS) begin
                        ev = '{EVT_HELD, held_key[i], 1'b0, 1'b0};
                        expected_events.insert(expected_events.size(), ev);
                        n_held++;
                    end
                end
                if (n_held > 0) begin
                    expected_events[expected_events.size() - 1].last = 1'b1;
                end
            end
            default: begin
                // unused operation code: nothing changes
            end
        endcase
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_fail++;
        end
    endfunction

    // Driver: present the next pending command once the last one has transferred
    always @(posedge i_clk) begin
        t_key_cmd c;
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (pending_cmds.size() > 0 &&
                (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
                c            = pending_cmds.pop_front();
                i_valid      <= 1'b1;
                i_operation  <= c.op;
                i_key_code   <= c.key;
                i_elapsed_ms <= c.elapsed;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: follow config and input transfers, check every result transfer
    always @(posedge i_clk) begin
        t_key_event want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            held_count = 0;
        end else begin
            i_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PCT);
            if (i_cfg_valid && o_cfg_ready)
                hold_delay = i_cfg_hold_delay_ms;
            if (i_valid && !o_stall)
                track_key_cmd('{i_operation, i_key_code, i_elapsed_ms});
            if (o_valid && !i_stall) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, actual kind %0d key %0d",
                             $time, o_event_kind, o_event_key);
                    n_fail++;
                end else begin
                    want = expected_events.pop_front();
                    compare_field("event_kind", want.kind, o_event_kind);
                    compare_field("event_key", want.key, o_event_key);
                    compare_field("table_overflow", want.overflow, o_table_overflow);
                    compare_field("last_of_run", want.last, o_last_of_run);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [TIME_W-1:0] elapsed);
        t_key_cmd c;
        c = '{op, key, elapsed};
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Wait until every command has transferred and every event has arrived,
    // then let a tick with nothing to report finish its walk
    task automatic settle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_valid || expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_hold_delay(logic [TIME_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_hold_delay_ms <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly presses, releases and ticks on a small set of keys so that
    // releases hit and slots expire; a few stray keys and unused codes
    task automatic random_phase(int n_cmds);
        logic [KEY_W-1:0]  keys[8];
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] elapsed;
        int                pick;
        int                n;
        n = 0;
        foreach (keys[i]) keys[i] = KEY_W'($urandom);
        while (n < n_cmds) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = OP_PRESS;
            else if (pick < 60) op = OP_RELEASE;
            else if (pick < 95) op = OP_TICK;
            else                op = OP_NONE;
            key = ($urandom_range(0, 99) < 85) ? keys[$urandom_range(0, 7)]
                                               : KEY_W'($urandom);
            case ($urandom_range(0, 9))
                0:       elapsed = '0;
                1:       elapsed = '1;
                2, 3, 4: elapsed = TIME_W'($urandom_range(0, 200));
                default: elapsed = TIME_W'($urandom);
            endcase
            push_cmd(op, key, elapsed);
            if (op != OP_NONE) n++;
        end
        settle();
    endtask

    // Stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, stray release, unused code, repeated press,
        // full table with overflow, and a tick that reports every slot
        push_cmd(OP_PRESS, '0, '0);
        push_cmd(OP_PRESS, '1, '1);
        push_cmd(OP_TICK, '0, '0);
        push_cmd(OP_TICK, '1, '1);
        push_cmd(OP_TICK, '0, '0);
        push_cmd(OP_NONE, '1, '1);
        push_cmd(OP_RELEASE, 9'd7, '0);
        push_cmd(OP_PRESS, '0, '0);
        push_cmd(OP_RELEASE, '0, '1);
        for (int i = 0; i < SLOTS - 1; i++)
            push_cmd(OP_PRESS, KEY_W'(i * 37 + 1), '0);
        push_cmd(OP_PRESS, 9'd300, '0);
        push_cmd(OP_TICK, '0, '1);
        push_cmd(OP_TICK, '1, '0);
        settle();

        write_hold_delay('0);
        random_phase(PHASE_CMDS);

        write_hold_delay('1);
        random_phase(PHASE_CMDS);

        // back to back on both sides
        no_gaps = 1'b1;
        write_hold_delay(TIME_W'($urandom_range(1, 300)));
        random_phase(PHASE_CMDS);
        no_gaps = 1'b0;

        write_hold_delay(TIME_W'($urandom));
        random_phase(PHASE_CMDS);

        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/core/khdt_pkg.sv
rtl/core/khdt_front.sv
rtl/core/khdt_queue.sv
rtl/core/khdt_back.sv
rtl/core/key_hold_delay_tracker_top.sv
tb/tb.sv
